/* rtl/i2cmw_pkg.sv */
// Shared types and constants for the write-only I2C master engine.
// No dependencies; imported by every module of the block.
package i2cmw_pkg;

    // Action codes carried by an input word.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_PUSH = 1'b1;

    // Reset value of the phase length register.
    localparam logic [7:0] PHASE_TICKS_RST = 8'd5;

    // One input word after classification by the front stage.
    typedef struct packed {
        logic       is_push;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       sda_in;
    } t_item;

    // One result word as presented on the output channel.
    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic need_byte;
        logic byte_taken;
        logic busy_res;
        logic done_res;
        logic nack;
    } t_result;

endpackage

/* rtl/i2cmw_front.sv */
// Front stage: registers incoming words and classifies them as tick or push.
// Depends on i2cmw_pkg for the item type and action codes.
module i2cmw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_last_byte,
    input  logic              i_sda_in,
    output logic              o_item_valid,
    input  logic              i_item_ready,
    output i2cmw_pkg::t_item  o_item
);
    import i2cmw_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Classify the word; the byte fields are cleared for a tick, and sda_in is passed on for every word.
    always_comb begin
        n_item.is_push   = (i_action == ACT_PUSH);
        n_item.tx_byte   = n_item.is_push ? i_tx_byte : 8'h00;
        n_item.last_byte = n_item.is_push & i_last_byte;
        n_item.sda_in    = i_sda_in;
    end

    // The stage refills in the same cycle that it hands its word on.
    assign o_ready = !r_valid || i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* rtl/i2cmw_queue.sv */
// Short first-in first-out queue between the front stage and the bus engine.
// Depends on i2cmw_pkg for the item type.
module i2cmw_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_ready,
    input  i2cmw_pkg::t_item  i_item,
    input  logic              i_pop,
    output logic              o_pop_valid,
    output i2cmw_pkg::t_item  o_item
);
    import i2cmw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointers wrap at the queue depth.
    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    // Occupancy never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    // A push into a full queue without a pop cannot change the count.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(DEPTH)) && !do_pop |=> r_count == CW'(DEPTH))
        else $error("full queue lost or gained a word");
`endif

endmodule

/* rtl/i2cmw_engine.sv */
// Back end: the I2C bus phase sequencer, phase length register and output register.
// Depends on i2cmw_pkg for the item and result types.
module i2cmw_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_item_valid,
    output logic               o_item_pop,
    input  i2cmw_pkg::t_item   i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cmw_pkg::t_result o_result
);
    import i2cmw_pkg::*;

    // Bus phase codes.
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_START_HOLD = 4'd1;
    localparam logic [3:0] PH_START_LOW  = 4'd2;
    localparam logic [3:0] PH_START_END  = 4'd3;
    localparam logic [3:0] PH_BIT_SETUP  = 4'd4;
    localparam logic [3:0] PH_BIT_HIGH   = 4'd5;
    localparam logic [3:0] PH_BIT_LOW    = 4'd6;
    localparam logic [3:0] PH_ACK_SETUP  = 4'd7;
    localparam logic [3:0] PH_ACK_HIGH   = 4'd8;
    localparam logic [3:0] PH_ACK_LOW    = 4'd9;
    localparam logic [3:0] PH_STOP_SETUP = 4'd10;
    localparam logic [3:0] PH_WAIT_BYTE  = 4'd11;
    localparam logic [3:0] PH_STOP_HIGH  = 4'd12;

    logic [7:0] r_phase_ticks;
    logic [3:0] r_phase,  n_phase;
    logic [7:0] r_count,  n_count;
    logic [2:0] r_bit,    n_bit;
    logic [7:0] r_shift,  n_shift;
    logic       r_final,  n_final;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    logic       r_nack,   n_nack;
    logic       r_out_valid;
    t_result    r_res,    n_res;

    logic [3:0] cur_phase;
    logic       waiting;
    logic [7:0] limit;
    logic [7:0] count_inc;
    logic       taken;
    logic       done;
    logic       done_nack;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_valid) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    // A word is taken from the queue whenever the output register can accept its result.
    assign o_item_pop = i_item_valid && (!r_out_valid || i_ready);

    assign cur_phase = (r_phase > PH_STOP_HIGH) ? PH_IDLE : r_phase;
    assign waiting   = (cur_phase == PH_IDLE) || (cur_phase == PH_WAIT_BYTE);
    assign limit     = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign count_inc = (r_count == 8'hFF) ? r_count : r_count + 8'd1;

    // Next bus state for the word at the head of the queue.
    always_comb begin
        n_phase   = cur_phase;
        n_count   = r_count;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_final   = r_final;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_nack    = r_nack;
        taken     = 1'b0;
        done      = 1'b0;
        done_nack = 1'b0;

        if (i_item.is_push) begin
            // A byte is loaded only when idle or between bytes.
            if (waiting) begin
                taken   = 1'b1;
                n_shift = i_item.tx_byte;
                n_final = i_item.last_byte;
                n_bit   = 3'd0;
                n_count = 8'd0;
                if (cur_phase == PH_IDLE) begin
                    n_nack  = 1'b0;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_START_HOLD;
                end else begin
                    n_sda   = i_item.tx_byte[7];
                    n_phase = PH_BIT_SETUP;
                end
            end
        end else if (!waiting) begin
            n_count = count_inc;
            if (count_inc >= limit) begin
                n_count = 8'd0;
                case (cur_phase)
                    PH_START_HOLD: begin
                        n_sda   = 1'b0;
                        n_phase = PH_START_LOW;
                    end
                    PH_START_LOW: begin
                        n_scl   = 1'b0;
                        n_phase = PH_START_END;
                    end
                    PH_START_END: begin
                        n_sda   = r_shift[7];
                        n_phase = PH_BIT_SETUP;
                    end
                    PH_BIT_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH: begin
                        n_scl   = 1'b0;
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        if (r_bit == 3'd7) begin
                            n_bit   = 3'd0;
                            n_sda   = 1'b1;
                            n_phase = PH_ACK_SETUP;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_sda   = r_shift[7];
                            n_phase = PH_BIT_SETUP;
                        end
                    end
                    PH_ACK_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        n_nack  = i_item.sda_in;
                        n_scl   = 1'b0;
                        n_phase = PH_ACK_LOW;
                    end
                    PH_ACK_LOW: begin
                        if (r_nack || r_final) begin
                            n_sda   = 1'b0;
                            n_phase = PH_STOP_SETUP;
                        end else begin
                            n_phase = PH_WAIT_BYTE;
                        end
                    end
                    PH_STOP_SETUP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_STOP_HIGH;
                    end
                    default: begin
                        // End of the STOP condition.
                        n_sda     = 1'b1;
                        done      = 1'b1;
                        done_nack = r_nack;
                        n_phase   = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result word seen after this step.
    always_comb begin
        n_res.scl_out    = n_scl;
        n_res.sda_out    = n_sda;
        n_res.need_byte  = (n_phase == PH_IDLE) || (n_phase == PH_WAIT_BYTE);
        n_res.byte_taken = taken;
        n_res.busy_res   = (n_phase != PH_IDLE);
        n_res.done_res   = done;
        n_res.nack       = done_nack;
    end

    // Bus state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= 8'd0;
            r_bit       <= 3'd0;
            r_shift     <= 8'd0;
            r_final     <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_nack      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_final <= n_final;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_nack  <= n_nack;
            end
            if (o_item_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // A completed STOP leaves the bus released and the engine idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.done_res |->
            !r_res.busy_res && r_res.scl_out && r_res.sda_out && r_res.need_byte)
        else $error("done reported while bus not released");

    // A NACK flag is only reported together with done.
    a_nack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.nack |-> r_res.done_res)
        else $error("nack without done");

    // An accepted byte always leaves a transfer in progress.
    a_taken_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.byte_taken |-> r_res.busy_res && !r_res.need_byte)
        else $error("byte taken but engine not busy");
`endif

endmodule

/* rtl/i2c_master_write_engine_core.sv */
// Top level of the write-only I2C master: front stage, word queue and bus engine.
// Depends on i2cmw_pkg, i2cmw_front, i2cmw_queue and i2cmw_engine.
//
//   Channel   Handshake                Payload
//   -------   ----------------------   -------------------------------------------
//   input     i_valid / o_ready        i_action, i_tx_byte, i_last_byte, i_sda_in
//   output    o_valid / i_ready        o_scl_out .. o_nack, one word per input word
//   config    i_cfg_valid / o_cfg_ready i_cfg_data (phase length in ticks)
//
// One word is accepted every cycle while o_ready is high; the phase sequencer steps once
// per word taken from the queue. A word's result passes the front register, the queue
// storage and then the engine's output register on its way to the outputs.
// Reset is synchronous and active low; the engine's scl and sda state resets released high.
// A stalled output holds the engine; the queue and front register then fill and o_ready falls.
module i2c_master_write_engine_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_tx_byte,
    input  logic       i_last_byte,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_need_byte,
    output logic       o_byte_taken,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_nack,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import i2cmw_pkg::*;

    logic    front_valid;
    logic    front_ready;
    t_item   front_item;
    logic    queue_valid;
    logic    queue_pop;
    t_item   queue_item;
    t_result result;

    // Input register and classification.
    i2cmw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_tx_byte    (i_tx_byte),
        .i_last_byte  (i_last_byte),
        .i_sda_in     (i_sda_in),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    // Decoupling queue.
    i2cmw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .o_push_ready (front_ready),
        .i_item       (front_item),
        .i_pop        (queue_pop),
        .o_pop_valid  (queue_valid),
        .o_item       (queue_item)
    );

    // Bus phase engine with output register.
    i2cmw_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (queue_valid),
        .o_item_pop   (queue_pop),
        .i_item       (queue_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_scl_out    = result.scl_out;
    assign o_sda_out    = result.sda_out;
    assign o_need_byte  = result.need_byte;
    assign o_byte_taken = result.byte_taken;
    assign o_busy_res   = result.busy_res;
    assign o_done_res   = result.done_res;
    assign o_nack       = result.nack;

endmodule
